// ===== sv/dmsn_pkg.sv =====
// Shared types, constants and helpers of the depth map surface normal block.
// No dependencies; used by every module of the block.
package dmsn_pkg;

	localparam int GRID_DIM   = 128;
	localparam int COL_W      = $clog2(GRID_DIM);
	localparam int DEPTH_W    = 8;
	localparam int DIM_W      = 8;
	localparam int K_W        = 10;
	localparam int GRAD_W     = DEPTH_W + 1;
	localparam int MAG_W      = 15;
	localparam int NORM_W     = 16;
	localparam int ONE_Q14    = 16384;
	localparam int FRAC_SH    = 30;
	localparam int SQ_W       = 2 * K_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int ACC_W      = 56;
	localparam int CROSS_W    = 40;
	localparam int BIT_W      = 4;
	localparam int SH_W       = 5;
	localparam int LANES      = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int WR_IDX_W   = 2;

	typedef enum logic [WR_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_FLAT_TERM   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_SUM,
		BK_ITER,
		BK_FINISH
	} back_state_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic [COL_W-1:0]         col;
		logic [COL_W-1:0]         row;
		logic                     done;
	} grad_item_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(3))
			r = DIM_W'(3);
		else if (v > DIM_W'(GRID_DIM))
			r = DIM_W'(GRID_DIM);
		return r;
	endfunction

endpackage

// ===== sv/dmsn_front.sv =====
// Front end: sample counters, the two line stores and the central differences.
// Depends on dmsn_pkg; feeds requests for the normalizer through dmsn_fifo.
module dmsn_front import dmsn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [DEPTH_W-1:0] depth_sample,
	input  logic [DIM_W-1:0]   grid_w,
	input  logic [DIM_W-1:0]   grid_h,
	output logic               item_valid,
	output grad_item_t         item,
	input  logic               item_ready
);

	logic [DEPTH_W-1:0] older_mem [GRID_DIM];
	logic [DEPTH_W-1:0] newer_mem [GRID_DIM];

	logic [COL_W-1:0]   col_q, row_q;
	logic               valid_s1, emit_s1, done_s1;
	logic [COL_W-1:0]   col_s1, row_s1;
	logic [DEPTH_W-1:0] d_s1, up_s1, mid_s1, right_s1, left_q;
	logic               advance, accept, emit, done;
	logic [DIM_W-1:0]   col_x, row_x;

	assign advance = !valid_s1 || !emit_s1 || item_ready;
	assign full    = !advance;
	assign accept  = push && advance;
	assign col_x   = {1'b0, col_q};
	assign row_x   = {1'b0, row_q};
	assign emit    = (row_x >= DIM_W'(2)) && (row_x < grid_h) && (col_x >= DIM_W'(1))
		&& ((col_x + DIM_W'(2)) <= grid_w);
	assign done    = (row_x == grid_h - DIM_W'(1)) && (col_x == grid_w - DIM_W'(2));

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1    <= older_mem[col_q];
			mid_s1   <= newer_mem[col_q];
			right_s1 <= newer_mem[col_q + COL_W'(1)];
			d_s1     <= depth_sample;
			col_s1   <= col_q;
			row_s1   <= row_q - COL_W'(1);
			emit_s1  <= emit;
			done_s1  <= done;
		end
		if (advance && valid_s1) begin
			older_mem[col_s1] <= mid_s1;
			newer_mem[col_s1] <= d_s1;
			left_q            <= mid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance)
				valid_s1 <= accept;
			if (accept) begin
				if ((col_x + DIM_W'(1)) >= grid_w) begin
					col_q <= '0;
					row_q <= ((row_x + DIM_W'(1)) >= grid_h) ? '0 : row_q + COL_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	assign item_valid = valid_s1 && emit_s1;
	assign item.gx    = $signed({1'b0, right_s1}) - $signed({1'b0, left_q});
	assign item.gy    = $signed({1'b0, d_s1}) - $signed({1'b0, up_s1});
	assign item.col   = col_s1;
	assign item.row   = row_s1;
	assign item.done  = done_s1;

endmodule

// ===== sv/dmsn_fifo.sv =====
// Short request queue between the front end and the normalizer.
// Depends on dmsn_pkg for the request type and depth.
module dmsn_fifo import dmsn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  grad_item_t wr_item,
	output logic       rd_valid,
	input  logic       rd_pop,
	output grad_item_t rd_item
);

	grad_item_t           slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_AW:0]     cnt_q;
	logic                 do_wr, do_rd;

	assign wr_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;
	assign rd_item  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + FIFO_AW'(1);
			if (do_rd)
				rp_q <= rp_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
		end
	end

endmodule

// ===== sv/dmsn_back.sv =====
// Normalizer: squares, sum and a bit-per-cycle search of each Q1.14 component.
// Depends on dmsn_pkg; takes requests from dmsn_fifo and holds one finished result.
module dmsn_back import dmsn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_pop,
	input  grad_item_t               in_item,
	input  logic [K_W-1:0]           flat_term,
	output logic                     out_valid,
	input  logic                     out_pop,
	output logic [COL_W-1:0]         out_col,
	output logic [COL_W-1:0]         out_row,
	output logic signed [NORM_W-1:0] out_nx,
	output logic signed [NORM_W-1:0] out_ny,
	output logic [MAG_W-1:0]         out_nz,
	output logic                     out_done
);

	back_state_t state_q, state_nxt;
	grad_item_t  item_q;
	logic [K_W-1:0]             mag_q  [LANES];
	logic [SQ_W-1:0]            sq_q   [LANES];
	logic signed [ACC_W-1:0]    p_q    [LANES];
	logic signed [CROSS_W-1:0]  q_q    [LANES];
	logic [MAG_W-1:0]           m_q    [LANES];
	logic signed [ACC_W-1:0]    cand   [LANES];
	logic                       hit    [LANES];
	logic [SUM_W-1:0]           s_q;
	logic [BIT_W-1:0]           bit_q;
	logic [SH_W-1:0]            sh_q, sh_s;
	logic                       load_out, out_valid_q;
	logic signed [GRAD_W:0]     gx_e, gy_e;

	assign gx_e = (GRAD_W+1)'(item_q.gx);
	assign gy_e = (GRAD_W+1)'(item_q.gy);
	assign sh_q = SH_W'(bit_q) + SH_W'(2);
	assign sh_s = SH_W'({bit_q, 1'b0}) + SH_W'(2);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			cand[i] = p_q[i] + (ACC_W'(q_q[i]) <<< sh_q)
				+ $signed(ACC_W'(s_q) << sh_s);
			hit[i]  = cand[i] <= $signed(ACC_W'({sq_q[i], FRAC_SH'(0)}));
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE:   if (in_valid) state_nxt = BK_SQUARE;
			BK_SQUARE: state_nxt = BK_SUM;
			BK_SUM:    state_nxt = BK_ITER;
			BK_ITER:   if (bit_q == '0) state_nxt = BK_FINISH;
			BK_FINISH: if (!out_valid_q || out_pop) state_nxt = BK_IDLE;
			default:   state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		in_pop   = (state_q == BK_IDLE) && in_valid;
		load_out = (state_q == BK_FINISH) && (!out_valid_q || out_pop);
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			item_q   <= in_item;
			mag_q[0] <= in_item.gx[GRAD_W-1] ? K_W'(-(GRAD_W+1)'(in_item.gx))
				: K_W'(in_item.gx);
			mag_q[1] <= in_item.gy[GRAD_W-1] ? K_W'(-(GRAD_W+1)'(in_item.gy))
				: K_W'(in_item.gy);
			mag_q[2] <= flat_term;
		end
		if (state_q == BK_SQUARE) begin
			for (int i = 0; i < LANES; i++)
				sq_q[i] <= mag_q[i] * mag_q[i];
		end
		if (state_q == BK_SUM) begin
			s_q   <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
			bit_q <= BIT_W'(MAG_W - 1);
			for (int i = 0; i < LANES; i++) begin
				p_q[i] <= ACC_W'(SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]));
				q_q[i] <= -$signed(CROSS_W'(SUM_W'(sq_q[0]) + SUM_W'(sq_q[1])
					+ SUM_W'(sq_q[2])));
				m_q[i] <= '0;
			end
		end
		if (state_q == BK_ITER) begin
			bit_q <= bit_q - BIT_W'(1);
			for (int i = 0; i < LANES; i++) begin
				if (hit[i]) begin
					p_q[i]        <= cand[i];
					q_q[i]        <= q_q[i] + $signed(CROSS_W'(s_q) << (sh_q - SH_W'(1)));
					m_q[i][bit_q] <= 1'b1;
				end
			end
		end
		if (load_out) begin
			out_col  <= item_q.col;
			out_row  <= item_q.row;
			out_done <= item_q.done;
			if (s_q == '0) begin
				out_nx <= '0;
				out_ny <= '0;
				out_nz <= MAG_W'(ONE_Q14);
			end else begin
				out_nx <= (gx_e > 0) ? -$signed(NORM_W'(m_q[0])) : $signed(NORM_W'(m_q[0]));
				out_ny <= (gy_e > 0) ? -$signed(NORM_W'(m_q[1])) : $signed(NORM_W'(m_q[1]));
				out_nz <= m_q[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_pop)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/depth_map_surface_normals.sv =====
// Depth map surface normals: takes one depth sample per cycle into the line
// stores while full is low; each interior grid point then costs the normalizer
// a request pop, squaring, sum, 15 search steps and a result load, so that loop
// sets the sustained rate of results, and a four-deep request queue lets samples
// keep flowing meanwhile. Border samples make no request. The line stores need
// no clearing after reset. Depends on dmsn_pkg, dmsn_front, dmsn_fifo, dmsn_back.
module depth_map_surface_normals import dmsn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [DEPTH_W-1:0]       depth_sample,
	output logic                     empty,
	input  logic                     pop,
	output logic [COL_W-1:0]         center_col,
	output logic [COL_W-1:0]         center_row,
	output logic signed [NORM_W-1:0] normal_x,
	output logic signed [NORM_W-1:0] normal_y,
	output logic [MAG_W-1:0]         normal_z,
	output logic                     frame_done,
	input  logic                     wr_en,
	input  logic [WR_IDX_W-1:0]      wr_index,
	input  logic [K_W-1:0]           wr_data
);

	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	logic [K_W-1:0]   flat_term_q;
	logic             f_valid, f_ready, b_valid, b_pop, out_valid;
	grad_item_t       f_item, b_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_W'(100);
			grid_height_q <= DIM_W'(100);
			flat_term_q   <= K_W'(100);
		end else if (wr_en) begin
			case (wr_index)
				REG_GRID_WIDTH:  grid_width_q  <= wr_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= wr_data[DIM_W-1:0];
				REG_FLAT_TERM:   flat_term_q   <= wr_data;
				default: ;
			endcase
		end
	end

	dmsn_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.depth_sample (depth_sample),
		.grid_w       (clamp_dim(grid_width_q)),
		.grid_h       (clamp_dim(grid_height_q)),
		.item_valid   (f_valid),
		.item         (f_item),
		.item_ready   (f_ready)
	);

	dmsn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_item  (f_item),
		.rd_valid (b_valid),
		.rd_pop   (b_pop),
		.rd_item  (b_item)
	);

	dmsn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_pop    (b_pop),
		.in_item   (b_item),
		.flat_term (flat_term_q),
		.out_valid (out_valid),
		.out_pop   (pop),
		.out_col   (center_col),
		.out_row   (center_row),
		.out_nx    (normal_x),
		.out_ny    (normal_y),
		.out_nz    (normal_z),
		.out_done  (frame_done)
	);

	assign empty = !out_valid;

	a_nz_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> normal_z <= MAG_W'(ONE_Q14))
		else $error("normal_z above one");

	a_nx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (normal_x <= NORM_W'(ONE_Q14)) && (normal_x >= -NORM_W'(ONE_Q14)))
		else $error("normal_x out of range");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (center_col != '0) && (center_row != '0))
		else $error("border point produced a normal");

endmodule
